// ===== design/prfe_pkg.sv =====
// ----------------------------------------------------------------------------
// prfe_pkg
// shared constants, operation codes and the dither pattern of the fill engine
// ----------------------------------------------------------------------------
package prfe_pkg;

    localparam int GRID_SIDE_DEF = 64;
    localparam int KIND_W        = 2;
    localparam int COORD_W       = 6;
    localparam int PVAL_W        = 3;
    localparam int PIX_W         = 2;
    localparam int COUNT_W       = 13;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

    typedef enum logic [KIND_W-1:0] {
        K_PAINT  = 2'd0,
        K_FILL   = 2'd1,
        K_RELIEF = 2'd2,
        K_READ   = 2'd3
    } t_kind;

    localparam logic [PIX_W-1:0] RELIEF_HI = 2'd0;
    localparam logic [PIX_W-1:0] RELIEF_LO = 2'd2;

    // one bit per column of the 16x16 pattern, set where the pixel is 3
    localparam logic [15:0] DITHER_ROWS [16] = '{
        16'h1111, 16'h0202, 16'h0404, 16'h0808,
        16'h1111, 16'h8080, 16'h4040, 16'h2020,
        16'h1111, 16'h0202, 16'h0404, 16'h0808,
        16'h1111, 16'h8080, 16'h4040, 16'h2020
    };

    function automatic logic [PIX_W-1:0] dither_at(input logic [3:0] y, input logic [3:0] x);
        logic [15:0] row_bits;
        row_bits = DITHER_ROWS[y];
        return row_bits[x] ? 2'd3 : 2'd0;
    endfunction

endpackage

// ===== design/pixel_region_fill_engine.sv =====
// ----------------------------------------------------------------------------
// pixel_region_fill_engine
// square 2-bit image with paint, 4-connected flood fill, relief and read
// ----------------------------------------------------------------------------
// Operations are issued with start while busy is low; each gives one result on
// o_strobe for a single cycle, and the receiver cannot stall it. After reset the
// engine clears the whole image memory, one pixel per cycle (2**(2*clog2(GRID_SIDE))
// pixels, 4096 by default), holding busy high. Paint reads the pixel, writes the
// new value where it differs and reads it back; read only reads the pixel. Fill
// and relief first clear the region marks over the same sweep, then grow the
// region through a stack memory, then rescan every pixel, with neighbor lookups
// for each region pixel in relief. The image, mark and stack memories each have
// one write port and one registered read port.
module pixel_region_fill_engine #(
    parameter int GRID_SIDE = prfe_pkg::GRID_SIDE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [prfe_pkg::KIND_W-1:0]   i_kind,
    input  logic [prfe_pkg::COORD_W-1:0]  i_column,
    input  logic [prfe_pkg::COORD_W-1:0]  i_row,
    input  logic [prfe_pkg::PVAL_W-1:0]   i_paint_value,
    output logic                          o_strobe,
    output logic [prfe_pkg::PIX_W-1:0]    o_pixel_value,
    output logic [prfe_pkg::COUNT_W-1:0]  o_changed_count
);
    import prfe_pkg::*;

    localparam int XW = $clog2(GRID_SIDE);
    localparam int AW = 2 * XW;
    localparam logic [XW-1:0] LAST = XW'(GRID_SIDE - 1);
    localparam logic [AW:0] CELLS = (AW+1)'(GRID_SIDE * GRID_SIDE);

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_PRD, S_PWR, S_MCLR, S_SRD, S_SPUSH, S_POP, S_PGET,
        S_NRD, S_NCHK, S_CRD, S_CCHK, S_RRD, S_RCHK, S_RWR, S_FRD, S_FGET
    } t_state;

    t_state              r_state;
    t_kind               r_kind;
    logic [XW-1:0]       r_x, r_y;
    logic [PVAL_W-1:0]   r_pv;
    logic [PIX_W-1:0]    r_val, r_pimg;
    logic [AW-1:0]       r_cnt, r_cur;
    logic [AW:0]         r_sp;
    logic [1:0]          r_nb;
    logic [3:0]          r_flags;
    logic [COUNT_W-1:0]  r_count, r_chg;
    logic [PIX_W-1:0]    r_pix;
    logic                r_strobe;

    logic                img_we, mark_we, stk_we;
    logic [AW-1:0]       img_waddr, img_raddr, mark_waddr, mark_raddr, stk_waddr, stk_raddr;
    logic [PIX_W-1:0]    img_wdata, img_rdata;
    logic                mark_wdata, mark_rdata;
    logic [AW-1:0]       stk_wdata, stk_rdata;

    logic [XW-1:0]       cx, cy;
    logic [AW-1:0]       tgt, nb_addr;
    logic                nb_ok, oor, last_cell;
    logic [PIX_W-1:0]    fill_val, paint_val, relief_val;
    logic                relief_wr;

    assign cx        = r_cur[XW-1:0];
    assign cy        = r_cur[AW-1:XW];
    assign tgt       = {r_y, r_x};
    assign oor       = (i_column >= GRID_SIDE) || (i_row >= GRID_SIDE);
    assign last_cell = (cx == LAST) && (cy == LAST);
    assign fill_val  = r_pv[2] ? dither_at(4'(cy), 4'(cx)) : r_pv[1:0];
    assign paint_val = r_pv[2] ? dither_at(4'(r_y), 4'(r_x)) : r_pv[1:0];

    // flags: 0 right, 1 left, 2 down, 3 up
    assign relief_wr  = !(r_flags[3] && r_flags[1]) || !(r_flags[2] && r_flags[0]);
    assign relief_val = !(r_flags[3] && r_flags[1]) ? RELIEF_HI : RELIEF_LO;

    always_comb begin
        unique case (r_nb)
            2'd0: begin
                nb_ok   = (cx != LAST);
                nb_addr = {cy, cx + XW'(1)};
            end
            2'd1: begin
                nb_ok   = (cx != '0);
                nb_addr = {cy, cx - XW'(1)};
            end
            2'd2: begin
                nb_ok   = (cy != LAST);
                nb_addr = {cy + XW'(1), cx};
            end
            default: begin
                nb_ok   = (cy != '0);
                nb_addr = {cy - XW'(1), cx};
            end
        endcase
    end

    always_comb begin
        img_we     = 1'b0;
        img_waddr  = r_cur;
        img_wdata  = '0;
        img_raddr  = tgt;
        mark_we    = 1'b0;
        mark_waddr = nb_addr;
        mark_wdata = 1'b1;
        mark_raddr = nb_addr;
        stk_we     = 1'b0;
        stk_waddr  = r_sp[AW-1:0];
        stk_wdata  = nb_addr;
        stk_raddr  = AW'(r_sp - (AW+1)'(1));
        unique case (r_state)
            S_INIT: begin
                img_we    = 1'b1;
                img_waddr = r_cnt;
            end
            S_PWR: begin
                img_waddr = tgt;
                img_wdata = paint_val;
                img_we    = (img_rdata != paint_val);
            end
            S_MCLR: begin
                mark_we    = 1'b1;
                mark_waddr = r_cnt;
                mark_wdata = 1'b0;
            end
            S_SPUSH: begin
                mark_we    = 1'b1;
                mark_waddr = tgt;
                stk_we     = 1'b1;
                stk_waddr  = '0;
                stk_wdata  = tgt;
            end
            S_NRD: begin
                img_raddr = nb_addr;
            end
            S_NCHK: begin
                mark_we = !mark_rdata && (img_rdata == r_val);
                stk_we  = !mark_rdata && (img_rdata == r_val);
            end
            S_CRD: begin
                img_raddr  = r_cur;
                mark_raddr = r_cur;
            end
            S_CCHK: begin
                img_wdata = fill_val;
                img_we    = mark_rdata && (r_kind == K_FILL) && (img_rdata != fill_val);
            end
            S_RWR: begin
                img_wdata = relief_val;
                img_we    = relief_wr && (r_pimg != relief_val);
            end
            default: begin
            end
        endcase
    end

    prfe_ram #(.WIDTH(PIX_W), .AW(AW)) u_img (
        .i_clk(i_clk), .i_we(img_we), .i_waddr(img_waddr), .i_wdata(img_wdata),
        .i_raddr(img_raddr), .o_rdata(img_rdata)
    );

    prfe_ram #(.WIDTH(1), .AW(AW)) u_mark (
        .i_clk(i_clk), .i_we(mark_we), .i_waddr(mark_waddr), .i_wdata(mark_wdata),
        .i_raddr(mark_raddr), .o_rdata(mark_rdata)
    );

    prfe_ram #(.WIDTH(AW), .AW(AW)) u_stk (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_cnt    <= '0;
            r_sp     <= '0;
            r_strobe <= 1'b0;
            r_count  <= '0;
        end else begin
            r_strobe <= 1'b0;
            if (img_we && r_state != S_INIT && r_count != COUNT_MAX) begin
                r_count <= r_count + COUNT_W'(1);
            end
            unique case (r_state)
                S_INIT: begin
                    r_cnt <= r_cnt + AW'(1);
                    if (r_cnt == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_kind  <= t_kind'(i_kind);
                        r_x     <= XW'(i_column);
                        r_y     <= XW'(i_row);
                        r_pv    <= i_paint_value;
                        r_count <= '0;
                        r_cnt   <= '0;
                        if (oor) begin
                            r_pix    <= '0;
                            r_chg    <= '0;
                            r_strobe <= 1'b1;
                        end else begin
                            unique case (t_kind'(i_kind))
                                K_PAINT:  r_state <= S_PRD;
                                K_READ:   r_state <= S_FRD;
                                default:  r_state <= S_MCLR;
                            endcase
                        end
                    end
                end
                S_PRD:  r_state <= S_PWR;
                S_PWR:  r_state <= S_FRD;
                S_MCLR: begin
                    r_cnt <= r_cnt + AW'(1);
                    if (r_cnt == '1) begin
                        r_state <= S_SRD;
                    end
                end
                S_SRD:  r_state <= S_SPUSH;
                S_SPUSH: begin
                    r_val   <= img_rdata;
                    r_sp    <= (AW+1)'(1);
                    r_state <= S_POP;
                end
                S_POP: begin
                    if (r_sp == '0) begin
                        r_cur   <= '0;
                        r_state <= S_CRD;
                    end else begin
                        r_sp    <= r_sp - (AW+1)'(1);
                        r_state <= S_PGET;
                    end
                end
                S_PGET: begin
                    r_cur   <= stk_rdata;
                    r_nb    <= '0;
                    r_state <= S_NRD;
                end
                S_NRD: begin
                    if (nb_ok) begin
                        r_state <= S_NCHK;
                    end else if (r_nb == 2'd3) begin
                        r_state <= S_POP;
                    end else begin
                        r_nb <= r_nb + 2'd1;
                    end
                end
                S_NCHK: begin
                    if (stk_we) begin
                        r_sp <= r_sp + (AW+1)'(1);
                    end
                    r_nb    <= r_nb + 2'd1;
                    r_state <= (r_nb == 2'd3) ? S_POP : S_NRD;
                end
                S_CRD:  r_state <= S_CCHK;
                S_CCHK: begin
                    if (mark_rdata && r_kind == K_RELIEF) begin
                        r_pimg  <= img_rdata;
                        r_nb    <= '0;
                        r_state <= S_RRD;
                    end else if (last_cell) begin
                        r_state <= S_FRD;
                    end else begin
                        r_cur   <= (cx == LAST) ? {cy + XW'(1), XW'(0)} : {cy, cx + XW'(1)};
                        r_state <= S_CRD;
                    end
                end
                S_RRD: begin
                    if (nb_ok) begin
                        r_state <= S_RCHK;
                    end else begin
                        r_flags[r_nb] <= 1'b0;
                        r_nb          <= r_nb + 2'd1;
                        if (r_nb == 2'd3) begin
                            r_state <= S_RWR;
                        end
                    end
                end
                S_RCHK: begin
                    r_flags[r_nb] <= mark_rdata;
                    r_nb          <= r_nb + 2'd1;
                    r_state       <= (r_nb == 2'd3) ? S_RWR : S_RRD;
                end
                S_RWR: begin
                    if (last_cell) begin
                        r_state <= S_FRD;
                    end else begin
                        r_cur   <= (cx == LAST) ? {cy + XW'(1), XW'(0)} : {cy, cx + XW'(1)};
                        r_state <= S_CRD;
                    end
                end
                S_FRD:  r_state <= S_FGET;
                S_FGET: begin
                    r_pix    <= img_rdata;
                    r_chg    <= r_count;
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_strobe        = r_strobe;
    assign o_pixel_value   = r_pix;
    assign o_changed_count = r_chg;

`ifndef ASSERT_OFF
    a_oor_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && oor) |=> (o_strobe && o_changed_count == '0))
        else $error("out of range operation gave no immediate empty result");
    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for more than one cycle");
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= CELLS)
        else $error("seed stack overflow");
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_sp == '0))
        else $error("seed stack not empty between operations");
`endif

endmodule

// ===== design/prfe_ram.sv =====
// ----------------------------------------------------------------------------
// prfe_ram
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
module prfe_ram #(
    parameter int WIDTH = 2,
    parameter int AW    = 12
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [2**AW];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
